@@ rtl/tbbc_pkg.sv @@
// ----------------------------------------------------------------------------
// tbbc_pkg
// Shared constants and types for the three-band biquad crossover.
// ----------------------------------------------------------------------------
`default_nettype none

package tbbc_pkg;

  localparam int SAMPLE_WIDTH    = 24;
  localparam int COEF_WIDTH      = 32;
  localparam int NUM_FILTERS     = 6;
  localparam int COEF_PER_FILTER = 5;
  localparam int NUM_COEFS       = NUM_FILTERS * COEF_PER_FILTER;
  localparam int HIST_PER_FILTER = 4;
  localparam int NUM_HIST        = NUM_FILTERS * HIST_PER_FILTER;
  localparam int COEF_IDX_W      = 5;
  localparam int FILT_W          = 3;
  localparam int TERM_W          = 3;

  localparam logic [FILT_W-1:0] F_COUPLING = 3'd0;
  localparam logic [FILT_W-1:0] F_LOW_A    = 3'd1;
  localparam logic [FILT_W-1:0] F_HIGH_A   = 3'd2;
  localparam logic [FILT_W-1:0] F_LOW_B    = 3'd3;
  localparam logic [FILT_W-1:0] F_HIGH_B   = 3'd4;
  localparam logic [FILT_W-1:0] F_ROLLOFF  = 3'd5;

  localparam logic [TERM_W-1:0] T_B0 = 3'd0;
  localparam logic [TERM_W-1:0] T_A1 = 3'd3;
  localparam logic [TERM_W-1:0] T_A2 = 3'd4;

  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_COEF   = 1'b1;

  localparam logic REG_COUPLING = 1'b0;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_MAC,
    ST_FIN
  } state_e;

endpackage

`default_nettype wire

@@ rtl/three_band_biquad_crossover_top.sv @@
// ----------------------------------------------------------------------------
// three_band_biquad_crossover_top
// Six direct-form-I biquads splitting audio into low, mid and high bands.
// ----------------------------------------------------------------------------
// Each sample beat that is not a bypass runs through the six biquads, or
// five with the coupling filter off: a single serial-parallel multiplier
// walks the sample operand one bit per cycle and its shifted coefficient is
// added into or subtracted from one accumulator. Bypass samples and
// coefficient writes are taken in the idle state. The result is held in an
// output register, so the next beat is taken once it has gone or is going.
`default_nettype none

module three_band_biquad_crossover_top #(
  parameter int SAMPLE_WIDTH = tbbc_pkg::SAMPLE_WIDTH,
  parameter int COEF_WIDTH   = tbbc_pkg::COEF_WIDTH
) (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  wire                                 psel,
  input  wire                                 penable,
  input  wire                                 pwrite,
  input  wire  [2:0]                          paddr,
  input  wire  [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready,
  input  wire                                 in_valid_i,
  output logic                                in_ready_o,
  input  wire                                 command_i,
  input  wire  signed [SAMPLE_WIDTH-1:0]      sample_in_i,
  input  wire                                 bypass_i,
  input  wire  [tbbc_pkg::COEF_IDX_W-1:0]     coef_index_i,
  input  wire  signed [COEF_WIDTH-1:0]        coef_value_i,
  output logic                                out_valid_o,
  input  wire                                 out_ready_i,
  output logic signed [SAMPLE_WIDTH-1:0]      low_band_o,
  output logic signed [SAMPLE_WIDTH-1:0]      mid_band_o,
  output logic signed [SAMPLE_WIDTH-1:0]      high_band_o
);

  localparam int SW    = SAMPLE_WIDTH;
  localparam int CW    = COEF_WIDTH;
  localparam int AW    = SW + CW + 3;
  localparam int CF    = CW - 4;
  localparam int BIT_W = $clog2(SW);

  localparam logic signed [AW-1:0] RND  = AW'(1) <<< (CF - 1);
  localparam logic signed [AW-1:0] QMAX = AW'((64'(1) << (SW - 1)) - 64'(1));
  localparam logic signed [AW-1:0] QMIN = ~QMAX;

  tbbc_pkg::state_e state_q, state_d;

  logic                         cen_q;
  logic signed [CW-1:0]         coef_q [tbbc_pkg::NUM_COEFS];
  logic signed [SW-1:0]         hist_q [tbbc_pkg::NUM_HIST];
  logic signed [SW-1:0]         x_q, t_q, y2_q, y4_q;
  logic [tbbc_pkg::FILT_W-1:0]  filt_q;
  logic [tbbc_pkg::TERM_W-1:0]  term_q;
  logic [BIT_W-1:0]             bit_q;
  logic signed [AW-1:0]         acc_q, csh_q;
  logic [SW-1:0]                ssh_q;
  logic                         neg_q;
  logic                         ov_q;
  logic signed [SW-1:0]         low_q, mid_q, high_q;

  logic                         cfg_wr, in_acc, ov_set;
  logic signed [SW-1:0]         x0, opnd, y;
  logic [tbbc_pkg::COEF_IDX_W-1:0] cidx, hidx;
  logic signed [AW-1:0]         rnd, shr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr[2] == tbbc_pkg::REG_COUPLING) ? {31'b0, cen_q} : 32'b0;

  assign in_ready_o  = (state_q == tbbc_pkg::ST_IDLE) && (!ov_q || out_ready_i);
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_valid_o = ov_q;
  assign low_band_o  = low_q;
  assign mid_band_o  = mid_q;
  assign high_band_o = high_q;

  assign ov_set = (in_acc && command_i == tbbc_pkg::CMD_SAMPLE && bypass_i)
               || (state_q == tbbc_pkg::ST_FIN && filt_q == tbbc_pkg::F_ROLLOFF);

  always_comb begin
    case (filt_q)
      tbbc_pkg::F_COUPLING: x0 = x_q;
      tbbc_pkg::F_LOW_B:    x0 = y2_q;
      tbbc_pkg::F_ROLLOFF:  x0 = y4_q;
      default:              x0 = t_q;
    endcase
  end

  assign cidx = tbbc_pkg::COEF_IDX_W'({filt_q, 2'b00}) + tbbc_pkg::COEF_IDX_W'(filt_q)
              + tbbc_pkg::COEF_IDX_W'(term_q);
  assign hidx = tbbc_pkg::COEF_IDX_W'({filt_q, 2'b00}) + tbbc_pkg::COEF_IDX_W'(term_q)
              - tbbc_pkg::COEF_IDX_W'(1);
  assign opnd = (term_q == tbbc_pkg::T_B0) ? x0 : hist_q[hidx];

  assign rnd = acc_q + RND;
  assign shr = rnd >>> CF;
  always_comb begin
    if (shr > QMAX) begin
      y = QMAX[SW-1:0];
    end else if (shr < QMIN) begin
      y = QMIN[SW-1:0];
    end else begin
      y = shr[SW-1:0];
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      tbbc_pkg::ST_IDLE: begin
        if (in_acc && command_i == tbbc_pkg::CMD_SAMPLE && !bypass_i) begin
          state_d = tbbc_pkg::ST_LOAD;
        end
      end
      tbbc_pkg::ST_LOAD: state_d = tbbc_pkg::ST_MAC;
      tbbc_pkg::ST_MAC: begin
        if (bit_q == BIT_W'(SW - 1)) begin
          state_d = (term_q == tbbc_pkg::T_A2) ? tbbc_pkg::ST_FIN : tbbc_pkg::ST_LOAD;
        end
      end
      tbbc_pkg::ST_FIN: begin
        state_d = (filt_q == tbbc_pkg::F_ROLLOFF) ? tbbc_pkg::ST_IDLE : tbbc_pkg::ST_LOAD;
      end
      default: state_d = tbbc_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tbbc_pkg::ST_IDLE;
      cen_q   <= 1'b1;
      ov_q    <= 1'b0;
      filt_q  <= '0;
      term_q  <= '0;
      bit_q   <= '0;
      x_q     <= '0;
      t_q     <= '0;
      y2_q    <= '0;
      y4_q    <= '0;
      acc_q   <= '0;
      csh_q   <= '0;
      ssh_q   <= '0;
      neg_q   <= 1'b0;
      low_q   <= '0;
      mid_q   <= '0;
      high_q  <= '0;
      for (int i = 0; i < tbbc_pkg::NUM_COEFS; i++) coef_q[i] <= '0;
      for (int i = 0; i < tbbc_pkg::NUM_HIST; i++) hist_q[i] <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_wr && paddr[2] == tbbc_pkg::REG_COUPLING) begin
        cen_q <= pwdata[0];
      end
      if (ov_set) begin
        ov_q <= 1'b1;
      end else if (out_ready_i) begin
        ov_q <= 1'b0;
      end
      unique case (state_q)
        tbbc_pkg::ST_IDLE: begin
          if (in_acc) begin
            if (command_i == tbbc_pkg::CMD_COEF) begin
              if (coef_index_i < tbbc_pkg::COEF_IDX_W'(tbbc_pkg::NUM_COEFS)) begin
                coef_q[coef_index_i] <= coef_value_i;
              end
            end else if (bypass_i) begin
              low_q  <= sample_in_i;
              mid_q  <= '0;
              high_q <= '0;
            end else begin
              x_q    <= sample_in_i;
              t_q    <= sample_in_i;
              filt_q <= cen_q ? tbbc_pkg::F_COUPLING : tbbc_pkg::F_LOW_A;
              term_q <= tbbc_pkg::T_B0;
              acc_q  <= '0;
            end
          end
        end
        tbbc_pkg::ST_LOAD: begin
          csh_q <= AW'(coef_q[cidx]);
          ssh_q <= opnd;
          neg_q <= (term_q == tbbc_pkg::T_A1) || (term_q == tbbc_pkg::T_A2);
          bit_q <= '0;
        end
        tbbc_pkg::ST_MAC: begin
          if (ssh_q[0]) begin
            if (neg_q ^ (bit_q == BIT_W'(SW - 1))) begin
              acc_q <= acc_q - csh_q;
            end else begin
              acc_q <= acc_q + csh_q;
            end
          end
          csh_q <= csh_q <<< 1;
          ssh_q <= ssh_q >> 1;
          bit_q <= bit_q + BIT_W'(1);
          if (bit_q == BIT_W'(SW - 1)) begin
            term_q <= term_q + tbbc_pkg::TERM_W'(1);
          end
        end
        tbbc_pkg::ST_FIN: begin
          // term has stepped past a2 here, so hidx sits one past the filter's y2
          hist_q[hidx - tbbc_pkg::COEF_IDX_W'(4)] <= x0;
          hist_q[hidx - tbbc_pkg::COEF_IDX_W'(3)] <= hist_q[hidx - tbbc_pkg::COEF_IDX_W'(4)];
          hist_q[hidx - tbbc_pkg::COEF_IDX_W'(2)] <= y;
          hist_q[hidx - tbbc_pkg::COEF_IDX_W'(1)] <= hist_q[hidx - tbbc_pkg::COEF_IDX_W'(2)];
          case (filt_q)
            tbbc_pkg::F_COUPLING: t_q   <= y;
            tbbc_pkg::F_LOW_A:    low_q <= y;
            tbbc_pkg::F_HIGH_A:   y2_q  <= y;
            tbbc_pkg::F_LOW_B:    mid_q <= y;
            tbbc_pkg::F_HIGH_B:   y4_q  <= y;
            default:              high_q <= y;
          endcase
          filt_q <= filt_q + tbbc_pkg::FILT_W'(1);
          term_q <= tbbc_pkg::T_B0;
          acc_q  <= '0;
        end
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ sim/crossover_checker.sv @@
// ----------------------------------------------------------------------------
// crossover_checker
// Watches the sample and band channels, runs a bit-exact model of the six
// biquads alongside the block and compares every band beat in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module crossover_checker (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               coupling_on_i,
  input  wire               in_valid_i,
  input  wire               in_ready_i,
  input  wire               command_i,
  input  wire signed [23:0] sample_in_i,
  input  wire               bypass_i,
  input  wire        [4:0]  coef_index_i,
  input  wire signed [31:0] coef_value_i,
  input  wire               out_valid_i,
  input  wire               out_ready_i,
  input  wire signed [23:0] low_band_i,
  input  wire signed [23:0] mid_band_i,
  input  wire signed [23:0] high_band_i,
  output int                fail_count_o,
  output int                pending_o
);

  typedef struct packed {
    logic signed [23:0] low;
    logic signed [23:0] mid;
    logic signed [23:0] high;
  } bands_t;

  logic signed [31:0] coefs [tbbc_pkg::NUM_COEFS];
  logic signed [23:0] hist  [tbbc_pkg::NUM_HIST];
  bands_t             band_q [$];

  assign pending_o = band_q.size();

  function automatic logic signed [23:0] round_sat(input logic signed [63:0] acc);
    logic signed [63:0] q;
    q = (acc + 64'sd134217728) >>> 28;
    if (q > 64'sd8388607) return 24'sh7fffff;
    if (q < -64'sd8388608) return 24'sh800000;
    return q[23:0];
  endfunction

  function automatic logic signed [23:0] biquad(input logic [tbbc_pkg::FILT_W-1:0] f,
                                                input logic signed [23:0] x0);
    int                 c;
    int                 h;
    logic signed [63:0] acc;
    logic signed [23:0] y;
    c = int'(f) * tbbc_pkg::COEF_PER_FILTER;
    h = int'(f) * tbbc_pkg::HIST_PER_FILTER;
    acc = 64'(coefs[c]) * 64'(x0) + 64'(coefs[c+1]) * 64'(hist[h])
        + 64'(coefs[c+2]) * 64'(hist[h+1]) - 64'(coefs[c+3]) * 64'(hist[h+2])
        - 64'(coefs[c+4]) * 64'(hist[h+3]);
    y = round_sat(acc);
    hist[h+1] = hist[h];
    hist[h]   = x0;
    hist[h+3] = hist[h+2];
    hist[h+2] = y;
    return y;
  endfunction

  task automatic report(input string what, input logic signed [23:0] got,
                        input logic signed [23:0] want);
    $display("mismatch %s: got %0d, want %0d at %0t", what, got, want, $time);
    fail_count_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    bands_t b;
    bands_t w;
    logic signed [23:0] t;
    logic signed [23:0] h1;
    logic signed [23:0] h2;
    if (!rst_ni) begin
      foreach (coefs[i]) coefs[i] = '0;
      foreach (hist[i]) hist[i] = '0;
      band_q.delete();
      fail_count_o = 0;
    end else begin
      if (in_valid_i && in_ready_i) begin
        if (command_i == tbbc_pkg::CMD_COEF) begin
          if (coef_index_i < tbbc_pkg::NUM_COEFS) coefs[coef_index_i] = coef_value_i;
        end else if (bypass_i) begin
          band_q.push_back('{sample_in_i, 24'sd0, 24'sd0});
        end else begin
          t = coupling_on_i ? biquad(tbbc_pkg::F_COUPLING, sample_in_i) : sample_in_i;
          b.low = biquad(tbbc_pkg::F_LOW_A, t);
          h1 = biquad(tbbc_pkg::F_HIGH_A, t);
          b.mid = biquad(tbbc_pkg::F_LOW_B, h1);
          h2 = biquad(tbbc_pkg::F_HIGH_B, t);
          b.high = biquad(tbbc_pkg::F_ROLLOFF, h2);
          band_q.push_back(b);
        end
      end
      if (out_valid_i && out_ready_i) begin
        if (band_q.size() == 0) begin
          $display("unexpected band beat at %0t", $time);
          fail_count_o++;
        end else begin
          w = band_q.pop_front();
          if (low_band_i !== w.low) report("low", low_band_i, w.low);
          if (mid_band_i !== w.mid) report("mid", mid_band_i, w.mid);
          if (high_band_i !== w.high) report("high", high_band_i, w.high);
        end
      end
    end
  end

endmodule

@@ sim/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Drives coefficient writes, samples and bypass beats into the crossover
// under varying idle patterns and coupling settings; the checker judges.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  wire [31:0] prdata;
  wire pready;
  logic in_valid_i = 1'b0;
  wire in_ready_o;
  logic command_i = tbbc_pkg::CMD_SAMPLE;
  logic signed [23:0] sample_in_i = '0;
  logic bypass_i = 1'b0;
  logic [4:0] coef_index_i = '0;
  logic signed [31:0] coef_value_i = '0;
  wire out_valid_o;
  logic out_ready_i = 1'b0;
  wire signed [23:0] low_band_o, mid_band_o, high_band_o;

  logic coupling_on = 1'b1;
  int   fail_count;
  int   pending;
  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  int   quiet_cycles = 0;

  localparam int WATCHDOG = 200000;

  three_band_biquad_crossover_top i_dut (.*);

  crossover_checker i_chk (
    .clk_i, .rst_ni, .coupling_on_i(coupling_on),
    .in_valid_i, .in_ready_i(in_ready_o), .command_i, .sample_in_i, .bypass_i,
    .coef_index_i, .coef_value_i, .out_valid_i(out_valid_o), .out_ready_i,
    .low_band_i(low_band_o), .mid_band_i(mid_band_o), .high_band_i(high_band_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > WATCHDOG) begin
      $display("three_band_biquad_crossover_top regression: fail");
      $finish;
    end
  end

  task automatic write_coupling(input logic on);
    @(posedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= 3'(tbbc_pkg::REG_COUPLING) * 3'd4;
    pwdata <= 32'(on);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    coupling_on = on;
  endtask

  task automatic send(input logic cmd, input logic signed [23:0] s, input logic byp,
                      input logic [4:0] idx, input logic signed [31:0] val);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1; command_i <= cmd; sample_in_i <= s; bypass_i <= byp;
    coef_index_i <= idx; coef_value_i <= val;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (800) @(posedge clk_i);
  endtask

  function automatic logic signed [31:0] rand_coef();
    case ($urandom_range(4))
      0: return $urandom();
      1: return 32'sh7fffffff;
      2: return 32'sh80000000;
      default: return $signed(32'($urandom_range(0, 1 << 29))) - 32'sd268435456;
    endcase
  endfunction

  function automatic logic signed [23:0] rand_sample();
    case ($urandom_range(5))
      0: return 24'sh7fffff;
      1: return 24'sh800000;
      default: return 24'($urandom());
    endcase
  endfunction

  task automatic random_phase(input int n);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(9))
        0: send(tbbc_pkg::CMD_COEF, rand_sample(), 1'($urandom()), 5'($urandom_range(31)),
                rand_coef());
        1: send(tbbc_pkg::CMD_SAMPLE, rand_sample(), 1'b1, 5'($urandom()), $urandom());
        default: send(tbbc_pkg::CMD_SAMPLE, rand_sample(), 1'b0, 5'($urandom()), $urandom());
      endcase
    end
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // untouched coefficients give silence, bypass passes the input
    send(tbbc_pkg::CMD_SAMPLE, 24'sh7fffff, 1'b0, '0, '0);
    send(tbbc_pkg::CMD_SAMPLE, 24'sh800000, 1'b1, '0, '0);
    send(tbbc_pkg::CMD_SAMPLE, 24'sh7fffff, 1'b1, '0, '0);
    send(tbbc_pkg::CMD_COEF, '0, 1'b0, 5'd30, 32'sh7fffffff);
    send(tbbc_pkg::CMD_COEF, '0, 1'b1, 5'd31, 32'sh80000000);
    for (int i = 0; i < tbbc_pkg::NUM_COEFS; i++)
      send(tbbc_pkg::CMD_COEF, '0, 1'b0, 5'(i), (i % 5 == 0) ? 32'sh10000000 : 32'sh0);
    send(tbbc_pkg::CMD_SAMPLE, 24'sh7fffff, 1'b0, '0, '0);
    send(tbbc_pkg::CMD_SAMPLE, 24'sh800000, 1'b0, '0, '0);
    send(tbbc_pkg::CMD_COEF, '0, 1'b0, 5'd5, 32'sh7fffffff);
    send(tbbc_pkg::CMD_SAMPLE, 24'sh7fffff, 1'b0, '0, '0);
    send(tbbc_pkg::CMD_SAMPLE, 24'sh800000, 1'b0, '0, '0);
    send(tbbc_pkg::CMD_SAMPLE, 24'sh000001, 1'b0, '0, '0);
    drain();
    write_coupling(1'b0);
    send(tbbc_pkg::CMD_SAMPLE, 24'sh123456, 1'b0, '0, '0);
    drain();
    write_coupling(1'b1);

    send_idle_pct = 13; recv_idle_pct = 79;
    random_phase(600);
    drain();
    write_coupling(1'b0);
    send_idle_pct = 79; recv_idle_pct = 13;
    random_phase(600);
    drain();
    write_coupling(1'b1);
    send_idle_pct = 0; recv_idle_pct = 0;
    random_phase(700);
    drain();

    if (fail_count == 0) $display("three_band_biquad_crossover_top regression: pass");
    else $display("three_band_biquad_crossover_top regression: fail");
    $finish;
  end

endmodule

@@ three_band_biquad_crossover_top.f @@
rtl/tbbc_pkg.sv
rtl/three_band_biquad_crossover_top.sv
sim/crossover_checker.sv
sim/tb.sv
